// File: rtl/mcas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcas_pkg
// Shared types and constants for the cursor acceleration step block.
// ----------------------------------------------------------------------------
package mcas_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_BASE_SPEED  = 2'd0;
    localparam logic [1:0] CFG_INIT_SPEED  = 2'd1;
    localparam logic [1:0] CFG_ACCEL_DUR   = 2'd2;
    localparam logic [1:0] CFG_UPD_INTV    = 2'd3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // reset values of the configuration registers
    localparam logic [7:0]  RST_BASE_SPEED = 8'd50;
    localparam logic [7:0]  RST_INIT_SPEED = 8'd15;
    localparam logic [15:0] RST_ACCEL_DUR  = 16'd800;
    localparam logic [7:0]  RST_UPD_INTV   = 8'd8;

    // one quotient bit per divide iteration
    localparam int DIV_STEPS = 8;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [7:0] ROUND_BIAS = 8'd64;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CMP   = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_SQ    = 8'b0000_1000,
        S_SPAN  = 8'b0001_0000,
        S_SUM   = 8'b0010_0000,
        S_SCALE = 8'b0100_0000,
        S_ACC   = 8'b1000_0000
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic cmp;
        logic div;
        logic sq;
        logic span;
        logic sum;
        logic scale;
        logic acc;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic moving;    // direction bit set on the offered input
        logic out_room;  // output register can take a result this cycle
    } t_dp_sts;

endpackage

// File: rtl/mcas_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcas_in_if
// Request channel: time stamp and held direction bits.
// ----------------------------------------------------------------------------
interface mcas_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] time_ms;
    logic        move_left;
    logic        move_right;
    logic        move_up;
    logic        move_down;

    modport source (output valid, time_ms, move_left, move_right, move_up, move_down,
                    input ready);
    modport sink   (input valid, time_ms, move_left, move_right, move_up, move_down,
                    output ready);
endinterface

// File: rtl/mcas_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcas_out_if
// Result channel: cursor deltas and pixel step.
// ----------------------------------------------------------------------------
interface mcas_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic        [7:0] pixel_step;

    modport source (output valid, delta_x, delta_y, pixel_step, input ready);
    modport sink   (input valid, delta_x, delta_y, pixel_step, output ready);
endinterface

// File: rtl/mcas_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcas_ctrl
// Sequencer: accept, compare, serial divide, multiply steps, output load.
// ----------------------------------------------------------------------------
module mcas_ctrl
    import mcas_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state               r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    // an item with no direction only updates the tracking state
                    if (i_sts.moving) n_state = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = S_SPAN;
            end
            S_SPAN: begin
                o_cmd.span = 1'b1;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_ACC;
            end
            S_ACC: begin
                // hold here while the previous result is still waiting
                if (i_sts.out_room) begin
                    o_cmd.acc = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/mcas_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcas_dp
// Datapath: config registers, tracking state, restoring divider, shared
// 12x8 multiplier, subpixel accumulator and output register.
// ----------------------------------------------------------------------------
module mcas_dp
    import mcas_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [15:0]           i_time_ms,
    input  logic                  i_move_left,
    input  logic                  i_move_right,
    input  logic                  i_move_up,
    input  logic                  i_move_down,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic signed [7:0]     o_delta_x,
    output logic signed [7:0]     o_delta_y,
    output logic [7:0]            o_pixel_step,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts
);

    logic [7:0]  r_base, r_init, r_intv;
    logic [15:0] r_dur;
    logic        r_was_moving;
    logic [15:0] r_start;
    logic [7:0]  r_carry;
    logic        r_left, r_right, r_up, r_down;
    logic [15:0] r_rem;
    logic [7:0]  r_quot;
    logic        r_sat, r_hi;
    logic [19:0] r_prod;
    logic [15:0] r_speed;
    logic        r_out_valid;
    logic [7:0]  r_dx, r_dy, r_px;

    logic [16:0] rem2;
    logic        rem_ge;
    logic [7:0]  step, sq_op, curve, span;
    logic [11:0] mul_a;
    logic [7:0]  mul_b;
    logic [19:0] mul_p;
    logic [15:0] acc_sum;
    logic [7:0]  acc_px;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= RST_BASE_SPEED;
            r_init <= RST_INIT_SPEED;
            r_dur  <= RST_ACCEL_DUR;
            r_intv <= RST_UPD_INTV;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE_SPEED: r_base <= i_cfg_data[7:0];
                CFG_INIT_SPEED: r_init <= i_cfg_data[7:0];
                CFG_ACCEL_DUR:  r_dur  <= i_cfg_data;
                CFG_UPD_INTV:   r_intv <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // restoring divide step: (elapsed << 8) / duration, one bit per cycle
    assign rem2   = {r_rem, 1'b0};
    assign rem_ge = (rem2 >= {1'b0, r_dur});

    assign step  = r_sat ? 8'hFF : r_quot;
    assign sq_op = step[7] ? (8'd0 - step) : step;
    assign curve = r_hi ? (8'd255 - r_prod[14:7]) : (8'd1 + r_prod[14:7]);
    assign span  = r_base - r_init;

    // shared multiplier operand select
    always_comb begin
        mul_a = {4'd0, sq_op};
        mul_b = sq_op;
        if (i_cmd.span) begin
            mul_a = {4'd0, span};
            mul_b = curve;
        end else if (i_cmd.scale) begin
            mul_a = r_speed[15:4];
            mul_b = r_intv;
        end
    end
    assign mul_p = {8'd0, mul_a} * {12'd0, mul_b};

    assign acc_sum = r_prod[15:0] + {8'd0, r_carry} + {8'd0, ROUND_BIAS};
    assign acc_px  = acc_sum[15:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_moving <= 1'b0;
            r_start      <= '0;
            r_carry      <= '0;
        end else begin
            if (i_cmd.accept) begin
                if (!r_was_moving) r_start <= i_time_ms;
                r_was_moving <= o_sts.moving;
            end
            if (i_cmd.acc) r_carry <= acc_sum[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rem   <= r_was_moving ? (i_time_ms - r_start) : 16'd0;
            r_left  <= i_move_left;
            r_right <= i_move_right;
            r_up    <= i_move_up;
            r_down  <= i_move_down;
        end
        if (i_cmd.cmp) begin
            r_sat  <= (r_rem >= r_dur);
            r_quot <= '0;
        end
        if (i_cmd.div) begin
            r_rem  <= rem_ge ? 16'(rem2 - {1'b0, r_dur}) : rem2[15:0];
            r_quot <= {r_quot[6:0], rem_ge};
        end
        if (i_cmd.sq) begin
            r_prod <= mul_p;
            r_hi   <= step[7];
        end
        if (i_cmd.span || i_cmd.scale) r_prod <= mul_p;
        if (i_cmd.sum) r_speed <= r_prod[15:0] + {r_init, 8'd0};
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_px <= acc_px;
            case ({r_left, r_right})
                2'b10:   r_dx <= 8'd0 - acc_px;
                2'b01:   r_dx <= acc_px;
                default: r_dx <= 8'd0;
            endcase
            case ({r_up, r_down})
                2'b10:   r_dy <= 8'd0 - acc_px;
                2'b01:   r_dy <= acc_px;
                default: r_dy <= 8'd0;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_delta_x    = r_dx;
    assign o_delta_y    = r_dy;
    assign o_pixel_step = r_px;

    assign o_sts.moving   = i_move_left | i_move_right | i_move_up | i_move_down;
    assign o_sts.out_room = !r_out_valid || i_out_ready;

endmodule

// File: rtl/mouse_cursor_accel_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_cursor_accel_step
// Key-driven cursor acceleration: one request in, at most one delta out.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries the millisecond time and four held-direction bits. A request
//   with no direction set produces no result; it only marks movement as
//   stopped. A request with a direction produces one transfer on o_rsp.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the block is idle (0 base speed, 1 initial speed, 2 duration, 3 interval).
// Sequence:
//   A moving request passes through accept, compare, the serial divider of
//   elapsed*256/duration, then five steps (square, blend, sum, scale,
//   accumulate) on the shared 12x8 multiplier and adders. The result is
//   valid once the accumulate step loads the output register. A request with
//   no direction leaves the sequencer idle. i_req.ready is high only while
//   the sequencer is idle.
// Stall:
//   The result sits in an output register, so the next request is accepted
//   and processed while it waits; that request holds in its last step until
//   the receiver takes the older result.
// Reset:
//   Synchronous, active low. Configuration returns to its defaults, movement
//   tracking and the subpixel remainder clear, and no result is pending.
// ----------------------------------------------------------------------------
module mouse_cursor_accel_step
    import mcas_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mcas_in_if.sink               i_req,
    mcas_out_if.source            o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    mcas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mcas_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_time_ms    (i_req.time_ms),
        .i_move_left  (i_req.move_left),
        .i_move_right (i_req.move_right),
        .i_move_up    (i_req.move_up),
        .i_move_down  (i_req.move_down),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_delta_x    (o_rsp.delta_x),
        .o_delta_y    (o_rsp.delta_y),
        .o_pixel_step (o_rsp.pixel_step),
        .i_cmd        (cmd),
        .o_sts        (sts)
    );

endmodule

// File: rtl/mcas_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcas_checker
// Port-level checks for the cursor acceleration step block.
// ----------------------------------------------------------------------------
module mcas_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_moving,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_delta_x,
    input logic [7:0] i_delta_y,
    input logic [7:0] i_pixel_step
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_delta_x)
            && $stable(i_delta_y) && $stable(i_pixel_step))
        else $error("result changed while stalled");

    // a delta is zero or plus/minus the pixel step
    a_dx_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_delta_x == 8'd0 || i_delta_x == i_pixel_step
            || i_delta_x == 8'(8'd0 - i_pixel_step)))
        else $error("delta_x not derived from pixel_step");

    a_dy_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_delta_y == 8'd0 || i_delta_y == i_pixel_step
            || i_delta_y == 8'(8'd0 - i_pixel_step)))
        else $error("delta_y not derived from pixel_step");

    // a moving request occupies the sequencer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_moving |=> !i_in_ready)
        else $error("ready high right after a moving transfer");

    // reset leaves no result pending
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind mouse_cursor_accel_step mcas_checker u_mcas_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_in_moving  (i_req.move_left | i_req.move_right | i_req.move_up | i_req.move_down),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_delta_x    (o_rsp.delta_x),
    .i_delta_y    (o_rsp.delta_y),
    .i_pixel_step (o_rsp.pixel_step)
);

// File: bench/mcas_step_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcas_step_checker
// Watches the configuration port and both channels of the cursor acceleration
// step block, predicts each cursor delta from its own copy of the movement
// state and settings, and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module mcas_step_checker
    import mcas_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mcas_in_if                    req_mon,
    mcas_out_if                   rsp_mon,
    output int                    o_err_cnt,
    output int                    o_pend_cnt
);

    typedef struct packed {
        logic [7:0] delta_x;
        logic [7:0] delta_y;
        logic [7:0] pixel_step;
    } t_cursor_delta;

    t_cursor_delta delta_q[$];
    int            mismatch_cnt;

    // settings as last written
    logic [7:0]  base_spd;
    logic [7:0]  init_spd;
    logic [15:0] dur_ms;
    logic [7:0]  intv_ms;

    // movement tracking
    logic        moving_q;
    logic [15:0] move_start;
    logic [7:0]  sub_carry;

    // position on the acceleration curve, 0..255
    function automatic logic [7:0] curve_pos(input logic [15:0] now);
        logic [15:0] elapsed;
        logic [23:0] ratio;
        elapsed = now - move_start;
        if (elapsed >= dur_ms) begin
            return 8'hFF;
        end
        ratio = {elapsed, 8'h00} / {8'h00, dur_ms};
        return ratio[7:0];
    endfunction

    // two-parabola sigmoid
    function automatic logic [7:0] curve_factor(input logic [7:0] pos);
        logic [16:0] sq;
        logic [8:0]  rem;
        if (pos < 8'd128) begin
            sq = {9'd0, pos} * {9'd0, pos};
            return 8'(17'd1 + (sq >> 7));
        end
        rem = 9'd256 - {1'b0, pos};
        sq  = {8'd0, rem} * {8'd0, rem};
        return 8'(17'd255 - (sq >> 7));
    endfunction

    // whole pixels for this update; keeps the fractional part
    function automatic logic [7:0] pixel_advance(input logic [15:0] now);
        logic [7:0]  factor;
        logic [7:0]  span;
        logic [31:0] spd;
        factor = curve_factor(curve_pos(now));
        span   = base_spd - init_spd;
        spd = (32'(span) * 32'(factor) + 32'(init_spd) * 32'd256) & 32'hFFFF;
        spd = spd >> 4;
        spd = (spd * 32'(intv_ms)) & 32'hFFFF;
        spd = (spd + 32'(sub_carry) + 32'(ROUND_BIAS)) & 32'hFFFF;
        sub_carry = spd[7:0];
        return spd[15:8];
    endfunction

    function automatic void predict_update(input logic [15:0] now,
                                           input logic l, r, u, d);
        t_cursor_delta exp_d;
        logic          moving;
        moving = l | r | u | d;
        if (!moving_q) begin
            move_start = now;
        end
        moving_q = moving;
        if (moving) begin
            exp_d.pixel_step = pixel_advance(now);
            exp_d.delta_x = 8'd0;
            exp_d.delta_y = 8'd0;
            if (l) exp_d.delta_x = exp_d.delta_x - exp_d.pixel_step;
            if (r) exp_d.delta_x = exp_d.delta_x + exp_d.pixel_step;
            if (u) exp_d.delta_y = exp_d.delta_y - exp_d.pixel_step;
            if (d) exp_d.delta_y = exp_d.delta_y + exp_d.pixel_step;
            delta_q.push_back(exp_d);
        end
    endfunction

    function automatic void check_field(input string name,
                                        input logic [7:0] want, got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%02h, got 0x%02h", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_cursor_delta exp_d;
        if (!i_rst_n) begin
            base_spd     = RST_BASE_SPEED;
            init_spd     = RST_INIT_SPEED;
            dur_ms       = RST_ACCEL_DUR;
            intv_ms      = RST_UPD_INTV;
            moving_q     = 1'b0;
            move_start   = 16'd0;
            sub_carry    = 8'd0;
            mismatch_cnt = 0;
            delta_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE_SPEED: base_spd = i_cfg_data[7:0];
                    CFG_INIT_SPEED: init_spd = i_cfg_data[7:0];
                    CFG_ACCEL_DUR:  dur_ms   = i_cfg_data[15:0];
                    CFG_UPD_INTV:   intv_ms  = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (delta_q.size() == 0) begin
                    $error("result with nothing pending: delta_x %0d delta_y %0d step %0d",
                           rsp_mon.delta_x, rsp_mon.delta_y, rsp_mon.pixel_step);
                    mismatch_cnt++;
                end else begin
                    exp_d = delta_q.pop_front();
                    check_field("delta_x", exp_d.delta_x, rsp_mon.delta_x);
                    check_field("delta_y", exp_d.delta_y, rsp_mon.delta_y);
                    check_field("pixel_step", exp_d.pixel_step, rsp_mon.pixel_step);
                end
            end
            if (req_mon.valid && req_mon.ready) begin
                predict_update(req_mon.time_ms, req_mon.move_left, req_mon.move_right,
                               req_mon.move_up, req_mon.move_down);
            end
        end
        o_err_cnt  <= mismatch_cnt;
        o_pend_cnt <= delta_q.size();
    end

endmodule

// File: bench/tb_mouse_cursor_accel_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mouse_cursor_accel_step
// Feeds the cursor acceleration step block with directed corner requests and
// then with random key-hold gestures under a range of settings, with random
// gaps on both channels and one long receiver hold-off; the checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_mouse_cursor_accel_step;
    import mcas_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RSP_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 20;
    localparam int PHASE_ITEMS     = 110;
    localparam int N_PHASES        = 12;

    // direction bits: {left, right, up, down}
    localparam logic [3:0] DIR_NONE  = 4'b0000;
    localparam logic [3:0] DIR_LEFT  = 4'b1000;
    localparam logic [3:0] DIR_RIGHT = 4'b0100;
    localparam logic [3:0] DIR_UP    = 4'b0010;
    localparam logic [3:0] DIR_DOWN  = 4'b0001;
    localparam logic [3:0] DIR_ALL   = 4'b1111;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int          err_cnt;
    int          pend_cnt;
    int          idle_cycles;
    logic [15:0] cur_dur;
    logic [15:0] now_ms;
    bit          req_steady;
    bit          rsp_steady;
    bit          rsp_hold_req;

    mcas_in_if  req_ch ();
    mcas_out_if rsp_ch ();

    mouse_cursor_accel_step dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    mcas_step_checker u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .req_mon    (req_ch),
        .rsp_mon    (rsp_ch),
        .o_err_cnt  (err_cnt),
        .o_pend_cnt (pend_cnt)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 80);
    endfunction

    task automatic send_req(input logic [15:0] t, input logic [3:0] dirs);
        int gap;
        req_ch.valid      <= 1'b1;
        req_ch.time_ms    <= t;
        req_ch.move_left  <= dirs[3];
        req_ch.move_right <= dirs[2];
        req_ch.move_up    <= dirs[1];
        req_ch.move_down  <= dirs[0];
        do @(posedge i_clk); while (!req_ch.ready);
        gap = req_steady ? 0 : pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // wait for every pending result, then let a trailing no-move request finish
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pend_cnt != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // upper data bits of the 8-bit registers are random: only the low byte counts
    task automatic write_regs(input logic [7:0] base, init, input logic [15:0] dur,
                              input logic [7:0] intv);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BASE_SPEED;
        i_cfg_data <= {8'($urandom), base};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_INIT_SPEED;
        i_cfg_data <= {8'($urandom), init};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ACCEL_DUR;
        i_cfg_data <= dur;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_UPD_INTV;
        i_cfg_data <= {8'($urandom), intv};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_dur = dur;
    endtask

    // key-hold gestures with random timing, plus some random noise requests
    task automatic run_mix(input int n_items);
        int         done_cnt;
        int         len;
        int         inc_max;
        logic [3:0] dirs;
        done_cnt = 0;
        while (done_cnt < n_items) begin
            if ($urandom_range(0, 9) < 8) begin
                len     = $urandom_range(1, 30);
                inc_max = (int'(cur_dur) / 12) + 1;
                dirs    = 4'($urandom_range(1, 15));
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        dirs = 4'($urandom_range(1, 15));
                    end
                    if ($urandom_range(0, 15) == 0) begin
                        now_ms += 16'($urandom);
                    end else begin
                        now_ms += 16'($urandom_range(0, inc_max));
                    end
                    send_req(now_ms, dirs);
                end
                now_ms += 16'($urandom_range(1, inc_max));
                send_req(now_ms, DIR_NONE);
                done_cnt += len + 1;
            end else begin
                now_ms = 16'($urandom);
                send_req(now_ms, 4'($urandom_range(0, 15)));
                done_cnt++;
            end
        end
    endtask

    // receiver: random stalls, steady stretches, and one long hold-off on request
    initial begin
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rsp_hold_req) begin
                rsp_ch.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(posedge i_clk);
                rsp_hold_req = 1'b0;
            end else if (rsp_steady || $urandom_range(0, 3) != 0) begin
                rsp_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_mouse_cursor_accel_step: done, errors");
            $finish;
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_BASE_SPEED;
        i_cfg_data        <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.time_ms    <= 16'd0;
        req_ch.move_left  <= 1'b0;
        req_ch.move_right <= 1'b0;
        req_ch.move_up    <= 1'b0;
        req_ch.move_down  <= 1'b0;
        req_steady   = 1'b0;
        rsp_steady   = 1'b0;
        rsp_hold_req = 1'b0;
        cur_dur      = RST_ACCEL_DUR;
        now_ms       = 16'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default settings: curve start, midpoint, end, exact duration, time wrap
        send_req(16'd100, DIR_NONE);
        send_req(16'd100, DIR_RIGHT);
        send_req(16'd499, DIR_UP);
        send_req(16'd500, DIR_LEFT | DIR_RIGHT);
        send_req(16'd899, DIR_UP);
        send_req(16'd900, DIR_DOWN);
        send_req(16'd65000, DIR_ALL);
        send_req(16'd0, DIR_NONE);
        send_req(16'd65535, DIR_LEFT);
        send_req(16'd10, DIR_RIGHT | DIR_DOWN);
        send_req(16'd11, DIR_UP | DIR_DOWN);
        send_req(16'd12, DIR_NONE);

        // initial speed above base, zero duration, widest interval
        drain_results();
        write_regs(8'd0, 8'd255, 16'd0, 8'd255);
        send_req(16'd20, DIR_LEFT);
        send_req(16'd21, DIR_UP);
        send_req(16'd22, DIR_RIGHT | DIR_UP);
        send_req(16'd23, DIR_NONE);

        // speed arithmetic overflow, longest duration
        drain_results();
        write_regs(8'd255, 8'd255, 16'd65535, 8'd255);
        send_req(16'd0, DIR_DOWN);
        send_req(16'd65534, DIR_LEFT);
        send_req(16'd65535, DIR_RIGHT);
        send_req(16'd1, DIR_NONE);

        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            case (p)
                0: write_regs(8'd255, 8'd0, 16'd1, 8'd255);
                1: write_regs(8'd0, 8'd255, 16'd65535, 8'd1);
                2: write_regs(8'd255, 8'd255, 16'd0, 8'd255);
                default: begin
                    case ($urandom_range(0, 2))
                        0: cur_dur = 16'($urandom_range(1, 64));
                        1: cur_dur = 16'($urandom_range(1, 2000));
                        default: cur_dur = 16'($urandom_range(1, 65535));
                    endcase
                    write_regs(8'($urandom), 8'($urandom), cur_dur,
                               ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 16))
                                                           : 8'($urandom_range(1, 255)));
                end
            endcase
            req_steady = ($urandom_range(0, 3) == 0);
            rsp_steady = ($urandom_range(0, 3) == 0);
            if (p == 3) begin
                // back up the output while requests keep coming
                rsp_hold_req = 1'b1;
                req_steady   = 1'b1;
                for (int k = 0; k < 8; k++) begin
                    now_ms += 16'd8;
                    send_req(now_ms, DIR_RIGHT | DIR_DOWN);
                end
                req_steady = 1'b0;
            end
            run_mix(PHASE_ITEMS);
        end

        drain_results();
        if (err_cnt == 0) begin
            $display("tb_mouse_cursor_accel_step: done, clean");
        end else begin
            $display("tb_mouse_cursor_accel_step: done, errors");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/mcas_pkg.sv
rtl/mcas_in_if.sv
rtl/mcas_out_if.sv
rtl/mcas_ctrl.sv
rtl/mcas_dp.sv
rtl/mouse_cursor_accel_step.sv
rtl/mcas_checker.sv
bench/mcas_step_checker.sv
bench/tb_mouse_cursor_accel_step.sv
